FILE: hw/rtl/depth_to_point_backprojection_unit_assert.svh
`ifndef DEPTH_TO_POINT_BACKPROJECTION_UNIT_ASSERT_SVH
`define DEPTH_TO_POINT_BACKPROJECTION_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define DPB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dpb assertion failed");

// next-cycle implication, checked outside reset
`define DPB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dpb assertion failed");

`endif

FILE: hw/rtl/dpb_pkg.sv
package dpb_pkg;

  localparam int MAX_SIDE   = 4096;
  localparam int CNT_W      = $clog2(MAX_SIDE);
  localparam int SIDE_W     = CNT_W + 1;
  localparam int DEPTH_BITS = 16;
  localparam int DEPTH_W    = 16;
  localparam int CENTER_W   = 16;
  localparam int INV_W      = 24;
  localparam int COORD_W    = 24;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int FRAC_SHIFT = 28;
  localparam int PROD_A_W   = CENTER_W + DEPTH_W;
  localparam int PROD_P_W   = PROD_A_W + INV_W;
  localparam int MAG_W      = PROD_P_W + 1 - FRAC_SHIFT;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_X  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_Y  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE    = 3'd7;

  localparam logic [SIDE_W-1:0]   RST_IMAGE_WIDTH  = 13'd640;
  localparam logic [SIDE_W-1:0]   RST_IMAGE_HEIGHT = 13'd480;
  localparam logic [CENTER_W-1:0] RST_CENTER_X     = 16'd5120;
  localparam logic [CENTER_W-1:0] RST_CENTER_Y     = 16'd3840;
  localparam logic [INV_W-1:0]    RST_INV_FOCAL    = 24'd32768;
  localparam logic [DEPTH_W-1:0]  RST_MIN_RANGE    = 16'd100;
  localparam logic [DEPTH_W-1:0]  RST_MAX_RANGE    = 16'd7000;

  typedef struct packed {
    logic [SIDE_W-1:0]   image_width;
    logic [SIDE_W-1:0]   image_height;
    logic [CENTER_W-1:0] center_x;
    logic [CENTER_W-1:0] center_y;
    logic [INV_W-1:0]    inv_focal_x;
    logic [INV_W-1:0]    inv_focal_y;
    logic [DEPTH_W-1:0]  min_range;
    logic [DEPTH_W-1:0]  max_range;
  } cfg_t;

  typedef struct packed {
    logic load_in;
    logic lane_y;
    logic mul_diff;
    logic mul_inv;
    logic cap_x;
    logic cap_y;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

FILE: hw/rtl/depth_to_point_backprojection_unit.sv
// Turns a raster stream of depth pixels into pinhole back-projected points, one
// result per pixel. Each pixel occupies the block through the transfer cycle,
// then a multiply by depth and a multiply by the focal reciprocal for x and
// then for y on one shared multiplier pair, a rounding step and the output
// write; no new pixel is taken until that write is done. The result sits in
// an output register, so a back-pressured result stalls only the final write.
// Rejected pixels give an all-zero point with point_valid low; frame_start
// restarts the column and row counters at the pixel that carries it. Registers
// are to be written by the user through cfg_we, cfg_index and cfg_data only
// while no pixel is in flight; the block itself does not enforce this.
module depth_to_point_backprojection_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [dpb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dpb_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [dpb_pkg::DEPTH_W-1:0]         depth,
  input  logic                                depth_present,
  input  logic                                frame_start,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [dpb_pkg::COORD_W-1:0]  point_x,
  output logic signed [dpb_pkg::COORD_W-1:0]  point_y,
  output logic [dpb_pkg::DEPTH_W-1:0]         point_z,
  output logic                                point_valid,
  output logic                                frame_last
);
  import dpb_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= RST_IMAGE_WIDTH;
      cfg.image_height <= RST_IMAGE_HEIGHT;
      cfg.center_x     <= RST_CENTER_X;
      cfg.center_y     <= RST_CENTER_Y;
      cfg.inv_focal_x  <= RST_INV_FOCAL;
      cfg.inv_focal_y  <= RST_INV_FOCAL;
      cfg.min_range    <= RST_MIN_RANGE;
      cfg.max_range    <= RST_MAX_RANGE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  cfg.image_width  <= cfg_data[SIDE_W-1:0];
        REG_IMAGE_HEIGHT: cfg.image_height <= cfg_data[SIDE_W-1:0];
        REG_CENTER_X:     cfg.center_x     <= cfg_data[CENTER_W-1:0];
        REG_CENTER_Y:     cfg.center_y     <= cfg_data[CENTER_W-1:0];
        REG_INV_FOCAL_X:  cfg.inv_focal_x  <= cfg_data[INV_W-1:0];
        REG_INV_FOCAL_Y:  cfg.inv_focal_y  <= cfg_data[INV_W-1:0];
        REG_MIN_RANGE:    cfg.min_range    <= cfg_data[DEPTH_W-1:0];
        REG_MAX_RANGE:    cfg.max_range    <= cfg_data[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  dpb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  dpb_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .depth         (depth),
    .depth_present (depth_present),
    .frame_start   (frame_start),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .point_x       (point_x),
    .point_y       (point_y),
    .point_z       (point_z),
    .point_valid   (point_valid),
    .frame_last    (frame_last)
  );

endmodule

FILE: hw/rtl/dpb_ctrl.sv
`include "depth_to_point_backprojection_unit_assert.svh"

module dpb_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  dpb_pkg::status_t status,
  output dpb_pkg::cmd_t    cmd
);
  import dpb_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    MUL_X,
    SCALE_X,
    MUL_Y,
    SCALE_Y,
    ROUND_Y,
    WRITE
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE:    if (in_valid) state <= MUL_X;
        MUL_X:   state <= SCALE_X;
        SCALE_X: state <= MUL_Y;
        MUL_Y:   state <= SCALE_Y;
        SCALE_Y: state <= ROUND_Y;
        ROUND_Y: state <= WRITE;
        WRITE:   if (status.out_free) state <= IDLE;
        default: state <= IDLE;
      endcase
    end
  end

  assign in_ready = (state == IDLE);

  always_comb begin
    cmd = '0;
    unique case (state)
      IDLE:    cmd.load_in = in_valid;
      MUL_X:   cmd.mul_diff = 1'b1;
      SCALE_X: cmd.mul_inv = 1'b1;
      MUL_Y: begin
        cmd.cap_x    = 1'b1;
        cmd.mul_diff = 1'b1;
        cmd.lane_y   = 1'b1;
      end
      SCALE_Y: begin
        cmd.mul_inv = 1'b1;
        cmd.lane_y  = 1'b1;
      end
      ROUND_Y: cmd.cap_y = 1'b1;
      WRITE:   cmd.load_out = status.out_free;
      default: cmd = '0;
    endcase
  end

  `DPB_ASSERT_NEXT(a_busy_after_transfer, cmd.load_in, !in_ready)
  `DPB_ASSERT_NOW(a_cap_y_follows_scale, cmd.cap_y, $past(cmd.mul_inv && cmd.lane_y))
  `DPB_ASSERT_NOW(a_out_only_when_free, cmd.load_out, status.out_free && !in_ready)

endmodule

FILE: hw/rtl/dpb_datapath.sv
`include "depth_to_point_backprojection_unit_assert.svh"

module dpb_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  dpb_pkg::cfg_t                   cfg,
  input  logic [dpb_pkg::DEPTH_W-1:0]     depth,
  input  logic                            depth_present,
  input  logic                            frame_start,
  input  dpb_pkg::cmd_t                   cmd,
  output dpb_pkg::status_t                status,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [dpb_pkg::COORD_W-1:0] point_x,
  output logic signed [dpb_pkg::COORD_W-1:0] point_y,
  output logic [dpb_pkg::DEPTH_W-1:0]     point_z,
  output logic                            point_valid,
  output logic                            frame_last
);
  import dpb_pkg::*;

  function automatic logic [COORD_W-1:0] sat_coord(input logic [MAG_W-1:0] mag,
                                                    input logic neg);
    logic [MAG_W-1:0] lim;
    logic [MAG_W-1:0] m;
    lim = neg ? MAG_W'(1) << (COORD_W - 1) : (MAG_W'(1) << (COORD_W - 1)) - MAG_W'(1);
    m   = (mag > lim) ? lim : mag;
    return neg ? COORD_W'(-m) : m[COORD_W-1:0];
  endfunction

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] s);
    logic [SIDE_W-1:0] r;
    r = s;
    if (s == '0) r = SIDE_W'(1);
    else if (s > SIDE_W'(MAX_SIDE)) r = SIDE_W'(MAX_SIDE);
    return r;
  endfunction

  logic [CNT_W-1:0]    col;
  logic [CNT_W-1:0]    row;
  logic [SIDE_W-1:0]   w;
  logic [SIDE_W-1:0]   h;
  logic [CNT_W-1:0]    u;
  logic [CNT_W-1:0]    v;
  logic [SIDE_W-1:0]   u_inc;
  logic [SIDE_W-1:0]   v_inc;
  logic [DEPTH_W-1:0]  z;
  logic                pix_ok;
  logic [CENTER_W-1:0] pos_x;
  logic [CENTER_W-1:0] pos_y;

  logic [DEPTH_W-1:0]  z_q;
  logic                ok_q;
  logic                last_q;
  logic                neg_x_q;
  logic                neg_y_q;
  logic [CENTER_W-1:0] diff_x_q;
  logic [CENTER_W-1:0] diff_y_q;
  logic [PROD_A_W-1:0] prod_a;
  logic [PROD_P_W-1:0] prod_p;
  logic [PROD_P_W:0]   rounded;
  logic [MAG_W-1:0]    mag_x;
  logic [MAG_W-1:0]    mag_y;

  always_comb begin
    w = clamp_side(cfg.image_width);
    h = clamp_side(cfg.image_height);
    // a shrunk image size after a config write folds stale counters back to zero
    if (frame_start || ({1'b0, col} >= w)) u = '0;
    else u = col;
    if (frame_start || ({1'b0, row} >= h)) v = '0;
    else v = row;
    u_inc  = {1'b0, u} + SIDE_W'(1);
    v_inc  = {1'b0, v} + SIDE_W'(1);
    z      = depth[DEPTH_BITS-1:0];
    pix_ok = depth_present && (z != '0) && (z >= cfg.min_range) && (z <= cfg.max_range);
    pos_x  = {u, 4'b0000};
    pos_y  = {v, 4'b0000};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (cmd.load_in) begin
      if (u_inc >= w) begin
        col <= '0;
        row <= (v_inc >= h) ? '0 : v_inc[CNT_W-1:0];
      end else begin
        col <= u_inc[CNT_W-1:0];
        row <= v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      z_q      <= z;
      ok_q     <= pix_ok;
      last_q   <= (u_inc == w) && (v_inc == h);
      neg_x_q  <= pos_x < cfg.center_x;
      neg_y_q  <= pos_y < cfg.center_y;
      diff_x_q <= (pos_x < cfg.center_x) ? cfg.center_x - pos_x : pos_x - cfg.center_x;
      diff_y_q <= (pos_y < cfg.center_y) ? cfg.center_y - pos_y : pos_y - cfg.center_y;
    end
  end

  // one shared multiplier pair, x lane first then y lane
  assign rounded = {1'b0, prod_p} + ((PROD_P_W + 1)'(1) << (FRAC_SHIFT - 1));

  always_ff @(posedge clk) begin
    if (cmd.mul_diff) begin
      prod_a <= PROD_A_W'((cmd.lane_y ? diff_y_q : diff_x_q)) * PROD_A_W'(z_q);
    end
    if (cmd.mul_inv) begin
      prod_p <= PROD_P_W'(prod_a) *
                PROD_P_W'((cmd.lane_y ? cfg.inv_focal_y : cfg.inv_focal_x));
    end
    if (cmd.cap_x) mag_x <= rounded[PROD_P_W:FRAC_SHIFT];
    if (cmd.cap_y) mag_y <= rounded[PROD_P_W:FRAC_SHIFT];
  end

  // output register, freed by a transfer on the result side
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      point_x     <= ok_q ? sat_coord(mag_x, neg_x_q) : '0;
      point_y     <= ok_q ? sat_coord(mag_y, neg_y_q) : '0;
      point_z     <= ok_q ? z_q : '0;
      point_valid <= ok_q;
      frame_last  <= last_q;
    end
  end

  assign status.out_free = !out_valid || out_ready;

  `DPB_ASSERT_NOW(a_reject_zero, out_valid && !point_valid,
                  point_x == '0 && point_y == '0 && point_z == '0)
  `DPB_ASSERT_NEXT(a_x_sign_pos, cmd.load_out && ok_q && !neg_x_q, !point_x[COORD_W-1])
  `DPB_ASSERT_NEXT(a_y_sign_neg, cmd.load_out && ok_q && neg_y_q,
                   point_y[COORD_W-1] || point_y == '0)

endmodule
